// ===== rtl/tbc_pkg.sv =====
// Shared types and constants for the TEA block cipher core.
// No dependencies; every other file in rtl/ but tbc_chan_if uses this package.
`timescale 1ns / 1ps
`default_nettype none

package tbc_pkg;

   localparam int unsigned WORD_W         = 32;
   localparam int unsigned ROUNDS_DEFAULT = 32;
   localparam int unsigned CSR_IDX_W      = 4;
   localparam logic [WORD_W-1:0] DELTA    = 32'h9e37_79b9;

   // Register map of the configuration channel
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD1 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD2 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_WORD3 = 4'd3;

   // Operation codes carried in the kind field
   localparam logic KIND_ENCIPHER = 1'b0;
   localparam logic KIND_DECIPHER = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] block_left;
      logic [WORD_W-1:0] block_right;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] result_left;
      logic [WORD_W-1:0] result_right;
   } rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] reg_index;
      logic [WORD_W-1:0]    reg_data;
   } csr_type;

   typedef struct packed {
      logic [WORD_W-1:0] word0;
      logic [WORD_W-1:0] word1;
      logic [WORD_W-1:0] word2;
      logic [WORD_W-1:0] word3;
   } key_type;

   // Block as it travels down the chain of cells
   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
   } stage_type;

   // n times delta, wrapped to a word; evaluated at elaboration only
   function automatic logic [WORD_W-1:0] round_sum(input int unsigned n);
      logic [2*WORD_W-1:0] prod;
      prod = (2*WORD_W)'(n) * (2*WORD_W)'(DELTA);
      return prod[WORD_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/tbc_chan_if.sv =====
// Valid/ready channel interface used by the request, response and CSR ports.
// Payload type is supplied per instance, normally from tbc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tbc_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/tbc_cell.sv =====
// One half-round cell of the TEA chain: updates one half of the block.
// Depends on tbc_pkg for word width and the stage type.
`timescale 1ns / 1ps
`default_nettype none

module tbc_cell #(
   parameter logic [tbc_pkg::WORD_W-1:0] SUM_ENC    = tbc_pkg::DELTA,
   parameter logic [tbc_pkg::WORD_W-1:0] SUM_DEC    = tbc_pkg::DELTA,
   parameter bit                         SECOND_HALF = 1'b0
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire logic                valid_prev,
   input  wire tbc_pkg::stage_type  data_prev,
   input  wire tbc_pkg::key_type    key,
   output logic                     valid_ff,
   output tbc_pkg::stage_type       data_ff
);

   logic                         tgt_is_left;
   logic [tbc_pkg::WORD_W-1:0]   src;
   logic [tbc_pkg::WORD_W-1:0]   tgt;
   logic [tbc_pkg::WORD_W-1:0]   key_a;
   logic [tbc_pkg::WORD_W-1:0]   key_b;
   logic [tbc_pkg::WORD_W-1:0]   sum;
   logic [tbc_pkg::WORD_W-1:0]   mix;
   logic [tbc_pkg::WORD_W-1:0]   tgt_new;
   tbc_pkg::stage_type           data_in;

   // Enciphering updates left then right; deciphering right then left.
   assign tgt_is_left = (SECOND_HALF == data_prev.kind);
   assign src   = tgt_is_left ? data_prev.right : data_prev.left;
   assign tgt   = tgt_is_left ? data_prev.left  : data_prev.right;
   assign key_a = tgt_is_left ? key.word0 : key.word2;
   assign key_b = tgt_is_left ? key.word1 : key.word3;
   assign sum   = (data_prev.kind == tbc_pkg::KIND_DECIPHER) ? SUM_DEC : SUM_ENC;

   assign mix = ((src << 4) + key_a) ^ (src + sum) ^ ((src >> 5) + key_b);
   assign tgt_new = (data_prev.kind == tbc_pkg::KIND_DECIPHER) ? (tgt - mix)
                                                               : (tgt + mix);

   always_comb begin
      data_in = data_prev;
      if (tgt_is_left) begin
         data_in.left = tgt_new;
      end else begin
         data_in.right = tgt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tbc_out_buffer.sv =====
// Two-entry output buffer (output register plus skid slot) for the response.
// Depends on tbc_pkg and tbc_chan_if.
`timescale 1ns / 1ps
`default_nettype none

module tbc_out_buffer (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push_valid,
   input  wire tbc_pkg::rsp_type   push_data,
   output logic                    advance,
   tbc_chan_if.source              rsp_chan
);

   logic              out_valid_ff;
   logic              out_valid_in;
   tbc_pkg::rsp_type  out_data_ff;
   tbc_pkg::rsp_type  out_data_in;
   logic              skid_valid_ff;
   logic              skid_valid_in;
   tbc_pkg::rsp_type  skid_data_ff;
   tbc_pkg::rsp_type  skid_data_in;
   logic              pop;
   logic              push;

   // Chain moves only while the skid slot is free, so a push always fits.
   assign advance = !skid_valid_ff;
   assign push    = push_valid && advance;
   assign pop     = out_valid_ff && rsp_chan.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_data_in  = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = push_data;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

`default_nettype wire

// ===== rtl/tea_block_cipher_core.sv =====
// TEA block cipher core: enciphers or deciphers 64-bit blocks with a 128-bit key.
// Depends on tbc_pkg, tbc_chan_if, tbc_cell and tbc_out_buffer.
//
// The core is a chain of 2*ROUNDS half-round cells, each updating one 32-bit
// half of the block, followed by a two-entry output buffer. It takes one block
// per cycle while request ready is high, and returns one result per block, in
// order. A block's result passes through each cell register in turn and then
// the output register, or the skid slot while that register is still full.
// Request ready depends only on a register and on reset: it is low while reset
// is asserted, and otherwise drops only when both output entries hold results
// the consumer has not yet taken, which stalls the whole chain. The key sits in
// four CSR words (index 0 to 3, reset to zero); writes to other indices are
// dropped, and the key must only change while no block is in flight. The CSR
// channel is always ready outside reset.
`timescale 1ns / 1ps
`default_nettype none

module tea_block_cipher_core #(
   parameter int unsigned ROUNDS = tbc_pkg::ROUNDS_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   tbc_chan_if.sink    req_chan,
   tbc_chan_if.source  rsp_chan,
   tbc_chan_if.sink    csr_chan
);

   localparam int unsigned CELLS = 2 * ROUNDS;

   tbc_pkg::key_type    key_ff;
   tbc_pkg::key_type    key_in;
   logic                advance;
   logic                chain_valid [CELLS+1];
   tbc_pkg::stage_type  chain_data  [CELLS+1];
   tbc_pkg::req_type    req_payload;
   tbc_pkg::csr_type    csr_payload;
   tbc_pkg::rsp_type    push_data;

   // Key registers: decode the index, drop writes outside the map.
   assign csr_chan.ready = !reset;
   assign csr_payload    = csr_chan.payload;

   always_comb begin
      key_in = key_ff;
      if (csr_chan.valid) begin
         unique case (csr_payload.reg_index)
            tbc_pkg::REG_KEY_WORD0: key_in.word0 = csr_payload.reg_data;
            tbc_pkg::REG_KEY_WORD1: key_in.word1 = csr_payload.reg_data;
            tbc_pkg::REG_KEY_WORD2: key_in.word2 = csr_payload.reg_data;
            tbc_pkg::REG_KEY_WORD3: key_in.word3 = csr_payload.reg_data;
            default:                key_in = key_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else begin
         key_ff <= key_in;
      end
   end

   // Head of the chain: request ready is high whenever the chain advances
   // outside reset; hold ready low in reset so no block is taken and dropped.
   assign req_chan.ready     = advance && !reset;
   assign req_payload        = req_chan.payload;
   assign chain_valid[0]     = req_chan.valid;
   assign chain_data[0].kind  = req_payload.kind;
   assign chain_data[0].left  = req_payload.block_left;
   assign chain_data[0].right = req_payload.block_right;

   // Cell pair r holds round r; its sum is fixed by position and mode.
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      tbc_cell #(
         .SUM_ENC     (tbc_pkg::round_sum((i / 2) + 1)),
         .SUM_DEC     (tbc_pkg::round_sum(ROUNDS - (i / 2))),
         .SECOND_HALF ((i % 2) == 1)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .valid_prev (chain_valid[i]),
         .data_prev  (chain_data[i]),
         .key        (key_ff),
         .valid_ff   (chain_valid[i+1]),
         .data_ff    (chain_data[i+1])
      );
   end

   // Tail of the chain: hand finished blocks to the output buffer.
   assign push_data.result_left  = chain_data[CELLS].left;
   assign push_data.result_right = chain_data[CELLS].right;

   tbc_out_buffer u_out_buffer (
      .clock      (clock),
      .reset      (reset),
      .push_valid (chain_valid[CELLS]),
      .push_data  (push_data),
      .advance    (advance),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tea_block_cipher_core: enciphers and deciphers blocks
// under a series of keys and checks every result against a TEA model or typed value.
// Depends on tbc_pkg and tbc_chan_if from the rtl folder.

module testbench;
   import tbc_pkg::*;

   localparam int unsigned NUM_ROUNDS       = ROUNDS_DEFAULT;
   // cell chain plus output register
   localparam int unsigned LATENCY          = 2*NUM_ROUNDS + 1;
   localparam int unsigned NUM_PHASES       = 9;
   localparam int unsigned BLOCKS_PER_PHASE = 190;
   localparam int unsigned DIRECTED_COUNT   = 18;
   localparam int unsigned CYCLE_LIMIT      = 200000;
   localparam int unsigned MAX_REPORTS      = 10;
   // indices past the key words; writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_FIRST = REG_KEY_WORD3 + 1'b1;
   localparam logic [CSR_IDX_W-1:0] REG_UNMAPPED_LAST  = '1;

   // one row of directed stimulus; 'typed' marks a hand-written expected block
   typedef struct packed {
      logic    typed;
      req_type blk;
      rsp_type want;
   } stim_row;

   logic clock;
   logic reset;

   tbc_chan_if #(.payload_type(req_type)) req_chan ();
   tbc_chan_if #(.payload_type(rsp_type)) rsp_chan ();
   tbc_chan_if #(.payload_type(csr_type)) csr_chan ();

   tea_block_cipher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Our own copy of the key, updated on every accepted CSR transfer
   key_type     key_shadow;
   // Predicted cipher outputs, oldest first, in request order
   rsp_type     predicted_blocks [$];
   stim_row     directed_rows [DIRECTED_COUNT];

   int unsigned error_count;
   int unsigned blocks_sent;
   int unsigned blocks_checked;
   int unsigned key_writes;
   int unsigned cycle_count;
   int unsigned send_gap_pct;
   int unsigned rsp_stall_pct;
   int unsigned stall_left;

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // TEA predictor
   // ------------------------------------------------------------------

   // Feistel mixing of one half with the running sum and two key words
   function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x,
                                                 input logic [WORD_W-1:0] sum,
                                                 input logic [WORD_W-1:0] ka,
                                                 input logic [WORD_W-1:0] kb);
      return ((x << 4) + ka) ^ (x + sum) ^ ((x >> 5) + kb);
   endfunction

   function automatic rsp_type tea_transform(input req_type blk, input key_type k);
      logic [WORD_W-1:0] left;
      logic [WORD_W-1:0] right;
      logic [WORD_W-1:0] sum;
      int unsigned       r;
      rsp_type           res;
      left  = blk.block_left;
      right = blk.block_right;
      if (blk.kind == KIND_ENCIPHER) begin
         sum = '0;
         for (r = 0; r < NUM_ROUNDS; r++) begin
            sum   += DELTA;
            left  += tea_mix(right, sum, k.word0, k.word1);
            right += tea_mix(left, sum, k.word2, k.word3);
         end
      end else begin
         // run the rounds backwards from the final sum, wrapped to a word
         sum = NUM_ROUNDS * DELTA;
         for (r = 0; r < NUM_ROUNDS; r++) begin
            right -= tea_mix(left, sum, k.word2, k.word3);
            left  -= tea_mix(right, sum, k.word0, k.word1);
            sum   -= DELTA;
         end
      end
      res.result_left  = left;
      res.result_right = right;
      return res;
   endfunction

   // Mostly random halves, with the word extremes mixed in
   function automatic logic [WORD_W-1:0] random_half();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return 32'h8000_0000;
         3:       return 32'h0000_0001;
         default: return $urandom();
      endcase
   endfunction

   task automatic flag_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("tb: mismatch: %s", what);
   endtask

   // ------------------------------------------------------------------
   // Request side: one block per call, called and returning at a falling edge.
   // Valid is left high on return so that a back-to-back block needs only one
   // assignment in the next step; callers drop it before waiting on anything.
   // ------------------------------------------------------------------
   task automatic send_block(input stim_row row);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < send_gap_pct) gap = $urandom_range(1, 6);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= row.blk;
      do @(posedge clock); while (!(req_chan.valid && req_chan.ready));
      // transfer taken: queue what the core must return for it
      predicted_blocks.push_back(row.typed ? row.want : tea_transform(row.blk, key_shadow));
      blocks_sent++;
      @(negedge clock);
   endtask

   // One CSR transfer; valid stays high for the next write, as above
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [WORD_W-1:0] data);
      csr_chan.valid   <= 1'b1;
      csr_chan.payload <= {index, data};
      do @(posedge clock); while (!(csr_chan.valid && csr_chan.ready));
      case (index)
         REG_KEY_WORD0: key_shadow.word0 = data;
         REG_KEY_WORD1: key_shadow.word1 = data;
         REG_KEY_WORD2: key_shadow.word2 = data;
         REG_KEY_WORD3: key_shadow.word3 = data;
         default: ;
      endcase
      key_writes++;
      @(negedge clock);
   endtask

   // Load a whole key, then hit an unmapped index that must change nothing
   task automatic load_key(input key_type k, input logic [CSR_IDX_W-1:0] stray_index);
      write_csr(REG_KEY_WORD0, k.word0);
      write_csr(REG_KEY_WORD1, k.word1);
      write_csr(REG_KEY_WORD2, k.word2);
      write_csr(REG_KEY_WORD3, k.word3);
      write_csr(stray_index, $urandom());
      csr_chan.valid <= 1'b0;
   endtask

   // Hold until every predicted block has come back; return at a falling edge
   task automatic wait_drained();
      while (predicted_blocks.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Response side: random stall bursts on ready
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (stall_left == 0 && rsp_stall_pct != 0 && $urandom_range(0, 99) < rsp_stall_pct)
         stall_left = $urandom_range(1, 6);
      if (stall_left != 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   // Compare each response transfer with the oldest prediction, field by field
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (predicted_blocks.size() == 0) begin
            flag_error($sformatf("unexpected result %h %h",
                                 rsp_chan.payload.result_left,
                                 rsp_chan.payload.result_right));
         end else begin
            want = predicted_blocks.pop_front();
            blocks_checked++;
            if (rsp_chan.payload.result_left !== want.result_left ||
                rsp_chan.payload.result_right !== want.result_right) begin
               flag_error($sformatf("block %0d: expected %h %h, got %h %h",
                                    blocks_checked, want.result_left, want.result_right,
                                    rsp_chan.payload.result_left,
                                    rsp_chan.payload.result_right));
            end
         end
      end
   end

   // Watchdog: a stuck handshake ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      stim_row     row;
      key_type     k;
      int unsigned phase;
      int unsigned n;

      clock            = 1'b0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b1;
      csr_chan.valid   = 1'b0;
      csr_chan.payload = '0;
      key_shadow       = '0;
      error_count      = 0;
      blocks_sent      = 0;
      blocks_checked   = 0;
      key_writes       = 0;
      cycle_count      = 0;
      send_gap_pct     = 15;
      rsp_stall_pct    = 10;
      stall_left       = 0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed blocks under the reset key of all zeros. The first pair is
      // the published all-zero vector and its inverse; the rest go to the
      // predictor: word extremes, single set bits and alternating patterns
      // in both modes.
      directed_rows = '{
         {1'b1, KIND_ENCIPHER, 32'h0000_0000, 32'h0000_0000, 32'h41ea_3a0a, 32'h94ba_a940},
         {1'b1, KIND_DECIPHER, 32'h41ea_3a0a, 32'h94ba_a940, 32'h0000_0000, 32'h0000_0000},
         {1'b0, KIND_ENCIPHER, 32'hffff_ffff, 32'hffff_ffff, 64'h0},
         {1'b0, KIND_DECIPHER, 32'hffff_ffff, 32'hffff_ffff, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'h0000_0000, 32'hffff_ffff, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'hffff_ffff, 32'h0000_0000, 64'h0},
         {1'b0, KIND_DECIPHER, 32'h0000_0000, 32'h0000_0000, 64'h0},
         {1'b0, KIND_DECIPHER, 32'h0000_0000, 32'hffff_ffff, 64'h0},
         {1'b0, KIND_DECIPHER, 32'hffff_ffff, 32'h0000_0000, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'h8000_0000, 32'h0000_0001, 64'h0},
         {1'b0, KIND_DECIPHER, 32'h0000_0001, 32'h8000_0000, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'haaaa_aaaa, 32'h5555_5555, 64'h0},
         {1'b0, KIND_DECIPHER, 32'h5555_5555, 32'haaaa_aaaa, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'h0123_4567, 32'h89ab_cdef, 64'h0},
         {1'b0, KIND_DECIPHER, 32'h89ab_cdef, 32'h0123_4567, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'h0000_0001, 32'h0000_0000, 64'h0},
         {1'b0, KIND_ENCIPHER, 32'h0000_0000, 32'h0000_0001, 64'h0},
         {1'b0, KIND_DECIPHER, 32'hfedc_ba98, 32'h7654_3210, 64'h0}
      };
      foreach (directed_rows[i]) send_block(directed_rows[i]);
      req_chan.valid <= 1'b0;
      wait_drained();

      // Random phases, each under its own key. The key changes only once
      // the chain is empty, since the core must not see it move mid-flight.
      for (phase = 1; phase <= NUM_PHASES; phase++) begin
         case (phase)
            1:          k = '1;
            2:          k = {32'h0000_0000, 32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff};
            3:          k = {32'hffff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0000};
            NUM_PHASES: k = '0;
            default:    k = {$urandom(), $urandom(), $urandom(), $urandom()};
         endcase
         load_key(k, (phase == 1) ? REG_UNMAPPED_LAST
                                  : CSR_IDX_W'($urandom_range(REG_UNMAPPED_FIRST,
                                                              REG_UNMAPPED_LAST)));

         // drop all idling in the last phase so the core runs at full rate
         if (phase == NUM_PHASES) begin
            send_gap_pct  = 0;
            rsp_stall_pct = 0;
         end else begin
            send_gap_pct  = $urandom_range(0, 30);
            rsp_stall_pct = $urandom_range(0, 25);
         end

         for (n = 0; n < BLOCKS_PER_PHASE; n++) begin
            // once mid-run, hold the sender until the pipeline has emptied
            if (phase == 2 && n == BLOCKS_PER_PHASE / 2) begin
               req_chan.valid <= 1'b0;
               wait_drained();
            end
            row.typed           = 1'b0;
            row.want            = '0;
            row.blk.kind        = $urandom_range(0, 1) ? KIND_DECIPHER : KIND_ENCIPHER;
            row.blk.block_left  = random_half();
            row.blk.block_right = random_half();
            send_block(row);
         end
         req_chan.valid <= 1'b0;
         wait_drained();
      end

      // let any stray extra result surface before deciding
      repeat (LATENCY + 8) @(posedge clock);

      $display("tb: summary: %0d blocks sent, %0d results checked, %0d CSR writes",
               blocks_sent, blocks_checked, key_writes);
      $display("tb: summary: both modes under %0d keys incl. all-zero and all-one, %0d errors",
               NUM_PHASES + 1, error_count);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
